// ===== rtl/blkalloc_pkg.sv =====
// ----------------------------------------------------------------------------
// blkalloc_pkg
// Shared types and constants of the bitmap block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package blkalloc_pkg;

   // pool geometry
   localparam int NUM_BLOCKS = 1024;
   localparam int WORD_W     = 32;
   localparam int WORDS      = NUM_BLOCKS / WORD_W;
   localparam int BIT_W      = $clog2(WORD_W);
   localparam int WADDR_W    = $clog2(WORDS);

   // field widths
   localparam int ACTION_W = 3;
   localparam int IDX_W    = 10;
   localparam int CNT_W    = 11;
   localparam int CKSUM_W  = 32;

   // action codes; any other code behaves as a query
   localparam logic [ACTION_W-1:0] ACT_ALLOC = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_FREE  = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_DIRTY = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_CKSUM = 3'd3;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_FULL    = 2'd1,
      STAT_RANGE   = 2'd2,
      STAT_UNALLOC = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [IDX_W-1:0]    block_index;
      logic [CKSUM_W-1:0]  checksum_value;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [IDX_W-1:0]    result_index;
      logic                is_allocated;
      logic                is_dirty;
      logic [CKSUM_W-1:0]  stored_checksum;
      logic [CNT_W-1:0]    free_count;
   } rsp_type;

   // one entry of the per-block data memory
   typedef struct packed {
      logic               dirty;
      logic [CKSUM_W-1:0] checksum;
   } blk_data_type;

endpackage : blkalloc_pkg

`default_nettype wire

// ===== rtl/block_allocator_bitmap_core.sv =====
// ----------------------------------------------------------------------------
// block_allocator_bitmap_core
// First-fit block allocator over a bitmap word memory and a per-block
// dirty/checksum memory.
// ----------------------------------------------------------------------------
// One request at a time. A transferred request goes through these steps in
// order: read the bitmap word and the block's data entry; modify and write
// them back; move the result into the output register, a step that waits
// while the result side is stalled. A new request is taken while the
// previous result still waits in the output register. Allocation picks the
// lowest non-full bitmap word from a per-word full flag and the lowest clear
// bit inside that word. Dirty mark and checksum of a free block always read
// as zero, so the data memory is never cleared; bitmap words carry a valid
// flag each, and a register write clears all flags at once, so there is no
// clearing pass after reset or after a register write.
// ----------------------------------------------------------------------------
`default_nettype none

module block_allocator_bitmap_core (
   input  wire logic                      clock,
   input  wire logic                      reset,

   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire blkalloc_pkg::req_type     req_payload,

   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output blkalloc_pkg::rsp_type          rsp_payload,

   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [blkalloc_pkg::CNT_W-1:0] csr_wdata
);

   import blkalloc_pkg::*;

   // memories
   logic [WORD_W-1:0]  bmap_mem [WORDS];
   blk_data_type       dmem     [NUM_BLOCKS];
   logic [WORD_W-1:0]  bmap_rd_ff;
   blk_data_type       dmem_rd_ff;

   // control
   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   usable_ff, usable_in;
   logic [CNT_W-1:0]   free_count_ff;
   logic [WORDS-1:0]   word_valid_ff;
   logic [WORDS-1:0]   full_ff;
   logic               rsp_valid_ff;

   // request and result holding
   req_type            req_ff;
   logic [WADDR_W-1:0] rd_word_ff;
   rsp_type            result_ff;
   rsp_type            rsp_payload_ff;

   // handshakes
   logic               req_xfer;
   logic               csr_xfer;
   logic               rsp_load;

   // read side
   logic [WADDR_W-1:0] alloc_word;
   logic [WADDR_W-1:0] bmap_raddr;

   // execute side
   logic [WORD_W-1:0]  word_rd;
   logic [BIT_W-1:0]   free_bit;
   logic [BIT_W-1:0]   idx_bit;
   logic               in_range;
   logic               exec_en;
   rsp_type            result_in;
   logic               bmap_we;
   logic [WORD_W-1:0]  bmap_wdata;
   logic               dmem_we;
   logic [IDX_W-1:0]   dmem_waddr;
   blk_data_type       dmem_wdata;
   logic [CNT_W-1:0]   free_count_in;

   // ------------------------------------------------------------------------
   // state machine
   // ------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && !csr_valid) state_in = S_EXEC;
         end
         S_EXEC: state_in = S_EMIT;
         S_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      csr_ready = 1'b0;
      exec_en   = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            // a register write wins over a request in the same cycle
            req_stall = csr_valid;
            csr_ready = 1'b1;
         end
         S_EXEC: exec_en = 1'b1;
         S_EMIT: rsp_load = !rsp_valid_ff || !rsp_stall;
         default: ;
      endcase
   end

   assign req_xfer = req_valid && !req_stall;
   assign csr_xfer = csr_valid && csr_ready;

   assign usable_in = (csr_wdata > CNT_W'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS) : csr_wdata;

   // ------------------------------------------------------------------------
   // read side: lowest word that still has a clear bit
   // ------------------------------------------------------------------------
   always_comb begin
      alloc_word = '0;
      for (int i = WORDS - 1; i >= 0; i--) begin
         if (!full_ff[i]) alloc_word = WADDR_W'(i);
      end
   end

   assign bmap_raddr = (req_payload.action == ACT_ALLOC) ? alloc_word
                                                         : req_payload.block_index[IDX_W-1:BIT_W];

   always_ff @(posedge clock) begin
      if (bmap_we) bmap_mem[rd_word_ff] <= bmap_wdata;
      if (req_xfer) bmap_rd_ff <= bmap_mem[bmap_raddr];
   end

   always_ff @(posedge clock) begin
      if (dmem_we) dmem[dmem_waddr] <= dmem_wdata;
      if (req_xfer) dmem_rd_ff <= dmem[req_payload.block_index];
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         req_ff     <= req_payload;
         rd_word_ff <= bmap_raddr;
      end
      if (exec_en) result_ff <= result_in;
      if (rsp_load) rsp_payload_ff <= result_ff;
   end

   // ------------------------------------------------------------------------
   // execute: modify the read word and entry, build the result
   // ------------------------------------------------------------------------
   always_comb begin
      word_rd = word_valid_ff[rd_word_ff] ? bmap_rd_ff : '0;
      free_bit = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (!word_rd[i]) free_bit = BIT_W'(i);
      end
   end

   assign idx_bit  = req_ff.block_index[BIT_W-1:0];
   assign in_range = {1'b0, req_ff.block_index} < usable_ff;

   always_comb begin
      result_in                 = '0;
      result_in.result_index    = req_ff.block_index;
      bmap_we                   = 1'b0;
      bmap_wdata                = word_rd;
      dmem_we                   = 1'b0;
      dmem_waddr                = req_ff.block_index;
      dmem_wdata                = dmem_rd_ff;
      free_count_in             = free_count_ff;

      if (req_ff.action == ACT_ALLOC) begin
         if (free_count_ff == '0) begin
            result_in.status       = STAT_FULL;
            result_in.result_index = '0;
         end else begin
            result_in.status       = STAT_OK;
            result_in.result_index = {rd_word_ff, free_bit};
            result_in.is_allocated = 1'b1;
            bmap_we                = 1'b1;
            bmap_wdata[free_bit]   = 1'b1;
            dmem_we                = 1'b1;
            dmem_waddr             = {rd_word_ff, free_bit};
            dmem_wdata             = '0;
            free_count_in          = free_count_ff - CNT_W'(1);
         end
      end else if (!in_range) begin
         result_in.status = STAT_RANGE;
      end else if (!word_rd[idx_bit]) begin
         // a free block always has clear marks
         result_in.status = STAT_UNALLOC;
      end else begin
         result_in.status          = STAT_OK;
         result_in.is_allocated    = 1'b1;
         result_in.is_dirty        = dmem_rd_ff.dirty;
         result_in.stored_checksum = dmem_rd_ff.checksum;
         unique case (req_ff.action)
            ACT_FREE: begin
               bmap_we                   = 1'b1;
               bmap_wdata[idx_bit]       = 1'b0;
               dmem_we                   = 1'b1;
               dmem_wdata                = '0;
               result_in.is_allocated    = 1'b0;
               result_in.is_dirty        = 1'b0;
               result_in.stored_checksum = '0;
               if (free_count_ff != '1) free_count_in = free_count_ff + CNT_W'(1);
            end
            ACT_DIRTY: begin
               dmem_we            = 1'b1;
               dmem_wdata.dirty   = 1'b1;
               result_in.is_dirty = 1'b1;
            end
            ACT_CKSUM: begin
               dmem_we                   = 1'b1;
               dmem_wdata.checksum       = req_ff.checksum_value;
               result_in.stored_checksum = req_ff.checksum_value;
            end
            default: ;
         endcase
      end

      bmap_we            = bmap_we && exec_en;
      dmem_we            = dmem_we && exec_en;
      result_in.free_count = free_count_in;
   end

   // ------------------------------------------------------------------------
   // control registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         usable_ff     <= CNT_W'(NUM_BLOCKS);
         free_count_ff <= CNT_W'(NUM_BLOCKS);
         word_valid_ff <= '0;
         full_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_xfer) begin
            usable_ff     <= usable_in;
            free_count_ff <= usable_in;
            word_valid_ff <= '0;
            full_ff       <= '0;
         end else if (exec_en) begin
            free_count_ff <= free_count_in;
            if (bmap_we) begin
               word_valid_ff[rd_word_ff] <= 1'b1;
               full_ff[rd_word_ff]       <= &bmap_wdata;
            end
         end
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------
`ifndef ASSERT_OFF
   a_free_bounded: assert property (@(posedge clock) disable iff (reset)
      free_count_ff <= usable_ff)
      else $error("free count above usable count");

   a_full_needs_valid: assert property (@(posedge clock) disable iff (reset)
      (full_ff & ~word_valid_ff) == '0)
      else $error("full flag on a word never written");

   a_req_to_exec: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> state_ff == S_EXEC)
      else $error("accepted request not executed");

   a_alloc_in_range: assert property (@(posedge clock) disable iff (reset)
      (exec_en && req_ff.action == ACT_ALLOC && free_count_ff != '0)
         |-> ({1'b0, rd_word_ff, free_bit} < usable_ff))
      else $error("allocation beyond usable count");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_EMIT))
      else $error("result raised outside emit");
`endif

endmodule : block_allocator_bitmap_core

`default_nettype wire
